// File: hdl/fus_pkg.sv
// ----------------------------------------------------------------------------
// fus_pkg
// Shared types and constants of the first unique symbol stream core.
// ----------------------------------------------------------------------------
package fus_pkg;

	// symbol reported when no symbol of the string has occurred exactly once
	localparam logic [7:0] FILLER_SYMBOL = 8'd35;

	// sequencer states of the core
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_POS,
		ST_CHECK,
		ST_SCAN,
		ST_SCAN_SYM,
		ST_SCAN_REP,
		ST_EMIT
	} state_t;

endpackage

// File: hdl/fus_sym_table.sv
// ----------------------------------------------------------------------------
// fus_sym_table
// Per-symbol table of list position and repeat flag, one read and one write
// port, read data registered. Swept to zero once after reset.
// ----------------------------------------------------------------------------
module fus_sym_table #(
	parameter int SYMBOL_BITS = 8,
	parameter int IDX_W       = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [SYMBOL_BITS-1:0] rd_addr,
	output logic [IDX_W-1:0]       rd_pos,
	output logic                   rd_rep,
	input  logic                   wr_en,
	input  logic [SYMBOL_BITS-1:0] wr_addr,
	input  logic [IDX_W-1:0]       wr_pos,
	input  logic                   wr_rep,
	output logic                   busy
);

	localparam int SYM_N   = 1 << SYMBOL_BITS;
	localparam int ENTRY_W = IDX_W + 1;

	logic [ENTRY_W-1:0]     sym_mem_q [SYM_N];
	logic [ENTRY_W-1:0]     rd_data_q;
	logic [SYMBOL_BITS-1:0] clr_addr_q;
	logic                   busy_q;

	// sweep pointer for the clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			busy_q     <= 1'b1;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + SYMBOL_BITS'(1);
			if (clr_addr_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// table write: clearing pass has priority
	always_ff @(posedge clk) begin
		if (busy_q) begin
			sym_mem_q[clr_addr_q] <= '0;
		end else if (wr_en) begin
			sym_mem_q[wr_addr] <= {wr_pos, wr_rep};
		end
	end

	// registered read, held while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= sym_mem_q[rd_addr];
		end
	end

	assign rd_pos = rd_data_q[ENTRY_W-1:1];
	assign rd_rep = rd_data_q[0];
	assign busy   = busy_q;

endmodule

// File: hdl/first_unique_symbol_stream_core.sv
// ----------------------------------------------------------------------------
// first_unique_symbol_stream_core
// Reports, after every symbol, the earliest symbol of the current string
// that has occurred exactly once.
// ----------------------------------------------------------------------------
// Each input transfer carries one symbol and a start flag. Each one gives
// exactly one output transfer with a found flag and the earliest once-seen
// symbol (or '#' when none). The block works on one symbol at a time. After
// taking a symbol, the sequencer steps through ST_RD_POS, ST_CHECK and
// ST_SCAN; when a list entry is pending it adds ST_SCAN_SYM and ST_SCAN_REP,
// repeated for every list entry the head pointer passes over because its
// symbol has repeated, before ST_EMIT hands the result to the output
// register. Each list entry is passed over at most once per string, so these
// skips are bounded by the number of distinct symbols. The next symbol is
// taken back in ST_IDLE once the result is loaded. The result is loaded only
// once the previous one has left the output register, so a stalled receiver
// adds its stall. The sequencer reads the symbol table and order list one at
// a time. A start flag costs nothing: the string is restarted by zeroing the
// list pointers, and table entries are checked against the order list. After
// reset the symbol table is swept once, during which no input transfer is
// accepted. A finished result waits in the output register while the next
// symbol is taken.
// ----------------------------------------------------------------------------
module first_unique_symbol_stream_core #(
	parameter int SYMBOL_BITS = 8,
	parameter int ORDER_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
	input  logic        s_axis_tuser,   // [0] start_req
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] first_unique
	output logic        m_axis_tuser    // [0] found
);

	import fus_pkg::*;

	localparam int IDX_W = $clog2(ORDER_DEPTH);
	localparam int CNT_W = $clog2(ORDER_DEPTH + 1);

	state_t state_q, state_d;

	logic [SYMBOL_BITS-1:0] sym_q;
	logic [CNT_W-1:0]       head_q;
	logic [CNT_W-1:0]       tail_q;
	logic [SYMBOL_BITS-1:0] list_mem_q [ORDER_DEPTH];
	logic [SYMBOL_BITS-1:0] list_rd_q;
	logic                   res_found_q;
	logic [SYMBOL_BITS-1:0] res_sym_q;
	logic                   out_valid_q;
	logic                   out_found_q;
	logic [7:0]             out_sym_q;

	logic                   tab_busy;
	logic                   tab_rd_en;
	logic [SYMBOL_BITS-1:0] tab_rd_addr;
	logic [IDX_W-1:0]       tab_rd_pos;
	logic                   tab_rd_rep;
	logic                   tab_wr_en;
	logic [IDX_W-1:0]       tab_wr_pos;
	logic                   tab_wr_rep;

	logic                   list_rd_en;
	logic [IDX_W-1:0]       list_rd_addr;
	logic                   list_wr_en;
	logic                   in_xfer;
	logic                   seen;
	logic                   room;
	logic                   pending;
	logic                   head_inc;
	logic                   res_load;
	logic                   res_found;
	logic                   out_load;

	fus_sym_table #(
		.SYMBOL_BITS (SYMBOL_BITS),
		.IDX_W       (IDX_W)
	) u_sym_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (tab_rd_en),
		.rd_addr (tab_rd_addr),
		.rd_pos  (tab_rd_pos),
		.rd_rep  (tab_rd_rep),
		.wr_en   (tab_wr_en),
		.wr_addr (sym_q),
		.wr_pos  (tab_wr_pos),
		.wr_rep  (tab_wr_rep),
		.busy    (tab_busy)
	);

	// symbol is in the current string if its entry points at a live list slot
	// that holds it; list not full while the tail is below the depth
	assign seen    = (CNT_W'(tab_rd_pos) < tail_q) && (list_rd_q == sym_q);
	assign room    = tail_q < CNT_W'(ORDER_DEPTH);
	assign pending = head_q < tail_q;
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid && !tab_busy) begin
					state_d = ST_RD_POS;
				end
			end
			ST_RD_POS:   state_d = ST_CHECK;
			ST_CHECK:    state_d = ST_SCAN;
			ST_SCAN: begin
				state_d = pending ? ST_SCAN_SYM : ST_EMIT;
			end
			ST_SCAN_SYM: state_d = ST_SCAN_REP;
			ST_SCAN_REP: begin
				state_d = tab_rd_rep ? ST_SCAN : ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		tab_rd_en     = 1'b0;
		tab_rd_addr   = sym_q;
		tab_wr_en     = 1'b0;
		tab_wr_pos    = tab_rd_pos;
		tab_wr_rep    = 1'b1;
		list_rd_en    = 1'b0;
		list_rd_addr  = head_q[IDX_W-1:0];
		list_wr_en    = 1'b0;
		head_inc      = 1'b0;
		res_load      = 1'b0;
		res_found     = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = !tab_busy;
				tab_rd_en     = 1'b1;
				tab_rd_addr   = SYMBOL_BITS'(s_axis_tdata);
			end
			ST_RD_POS: begin
				list_rd_en   = 1'b1;
				list_rd_addr = tab_rd_pos;
			end
			ST_CHECK: begin
				if (seen) begin
					tab_wr_en = 1'b1;
				end else if (room) begin
					tab_wr_en  = 1'b1;
					tab_wr_pos = tail_q[IDX_W-1:0];
					tab_wr_rep = 1'b0;
					list_wr_en = 1'b1;
				end
			end
			ST_SCAN: begin
				if (pending) begin
					list_rd_en = 1'b1;
				end else begin
					res_load = 1'b1;
				end
			end
			ST_SCAN_SYM: begin
				tab_rd_en   = 1'b1;
				tab_rd_addr = list_rd_q;
			end
			ST_SCAN_REP: begin
				if (tab_rd_rep) begin
					head_inc = 1'b1;
				end else begin
					res_load  = 1'b1;
					res_found = 1'b1;
				end
			end
			ST_EMIT: begin
				out_load = !out_valid_q || m_axis_tready;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	// state register and list pointers; start restarts the string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			state_q <= state_d;
			if (in_xfer && s_axis_tuser) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (head_inc) begin
					head_q <= head_q + CNT_W'(1);
				end
				if (list_wr_en) begin
					tail_q <= tail_q + CNT_W'(1);
				end
			end
		end
	end

	// captured symbol and result of the scan
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sym_q <= SYMBOL_BITS'(s_axis_tdata);
		end
		if (res_load) begin
			res_found_q <= res_found;
			res_sym_q   <= list_rd_q;
		end
	end

	// order list: symbols in order of first occurrence
	always_ff @(posedge clk) begin
		if (list_wr_en) begin
			list_mem_q[tail_q[IDX_W-1:0]] <= sym_q;
		end
		if (list_rd_en) begin
			list_rd_q <= list_mem_q[list_rd_addr];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q <= res_found_q;
			out_sym_q   <= res_found_q ? 8'(res_sym_q) : FILLER_SYMBOL;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_sym_q;
	assign m_axis_tuser  = out_found_q;

endmodule
